[rtl/ifpg_pkg.sv]
// shared constants for the infrared frame pulse generator
package ifpg_pkg;

    // operation codes of an input transaction
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // field and register widths
    localparam int unsigned WORD_IN_W  = 16;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned GAP_W      = 17;
    localparam int unsigned TICK_W     = 17;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned PHASE_W    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRE_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MARK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 3'd5;

    // register reset values
    localparam logic [DUR_W-1:0]     RST_PRE_MARK  = 16'd3600;
    localparam logic [DUR_W-1:0]     RST_PRE_SPACE = 16'd1200;
    localparam logic [DUR_W-1:0]     RST_LONG_MARK = 16'd1200;
    localparam logic [DUR_W-1:0]     RST_SHORT     = 16'd440;
    localparam logic [GAP_W-1:0]     RST_GAP       = 17'd73000;
    localparam logic [WORD_IN_W-1:0] RST_HEADER    = 16'h2002;

    // frame phases
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRE_MARK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PRE_SPACE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BIT_MARK  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BIT_SPACE = 3'd4;
    localparam logic [PHASE_W-1:0] PH_GAP       = 3'd5;

endpackage

[rtl/ir_frame_pulse_generator_top.sv]
// infrared frame pulse generator: phase sequencer driven by tick transactions
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------------
//   input    | in        | i_valid / o_stall  | i_operation, i_device_id, i_command_code
//   result   | out       | o_valid / i_stall  | o_carrier_on, o_busy_res, o_frame_done,
//            |           |                    | o_start_rejected
//   config   | in        | i_cfg_wr_en        | i_cfg_index, i_cfg_wdata
//
// Each input transaction updates the phase state and the result register at the
// edge that accepts it, so one transaction per clock while the result is not stalled.
// The result appears on the cycle after acceptance and is held while i_stall is high;
// input is taken again as soon as the held result leaves or in the same cycle.
// Synchronous active-low reset returns to idle with the default register values.
module ir_frame_pulse_generator_top #(
    parameter int unsigned WORD_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            i_cfg_wr_en,
    input  logic [ifpg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ifpg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic [ifpg_pkg::WORD_IN_W-1:0]  i_device_id,
    input  logic [ifpg_pkg::WORD_IN_W-1:0]  i_command_code,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_carrier_on,
    output logic                            o_busy_res,
    output logic                            o_frame_done,
    output logic                            o_start_rejected
);

    localparam int unsigned FRAME_LEN = 3 * WORD_BITS;
    localparam int unsigned CNT_W     = $clog2(FRAME_LEN);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_LEN - 1);

    // zero duration counts as one tick
    function automatic logic [ifpg_pkg::TICK_W-1:0] f_min1(
        input logic [ifpg_pkg::TICK_W-1:0] v
    );
        f_min1 = (v == '0) ? ifpg_pkg::TICK_W'(1) : v;
    endfunction

    // configuration registers
    logic [ifpg_pkg::DUR_W-1:0]     r_pre_mark;
    logic [ifpg_pkg::DUR_W-1:0]     r_pre_space;
    logic [ifpg_pkg::DUR_W-1:0]     r_long_mark;
    logic [ifpg_pkg::DUR_W-1:0]     r_short;
    logic [ifpg_pkg::GAP_W-1:0]     r_gap;
    logic [ifpg_pkg::WORD_IN_W-1:0] r_header;

    // sequencer state
    logic [ifpg_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [ifpg_pkg::TICK_W-1:0]  r_ticks, n_ticks;
    logic [CNT_W-1:0]             r_bit_cnt, n_bit_cnt;
    logic [FRAME_LEN-1:0]         r_frame, n_frame;

    // result register
    logic r_out_valid;
    logic r_carrier, r_busy, r_done, r_rejected;
    logic n_done, n_rejected;

    logic                        in_accept;
    logic [ifpg_pkg::TICK_W-1:0] ticks_dec;
    logic [ifpg_pkg::TICK_W-1:0] short_ticks;
    logic [ifpg_pkg::TICK_W-1:0] long_ticks;

    // input is taken while the result register is empty or being drained
    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;

    assign ticks_dec   = (r_ticks != '0) ? r_ticks - ifpg_pkg::TICK_W'(1) : '0;
    assign short_ticks = f_min1(ifpg_pkg::TICK_W'(r_short));
    assign long_ticks  = f_min1(ifpg_pkg::TICK_W'(r_long_mark));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_mark  <= ifpg_pkg::RST_PRE_MARK;
            r_pre_space <= ifpg_pkg::RST_PRE_SPACE;
            r_long_mark <= ifpg_pkg::RST_LONG_MARK;
            r_short     <= ifpg_pkg::RST_SHORT;
            r_gap       <= ifpg_pkg::RST_GAP;
            r_header    <= ifpg_pkg::RST_HEADER;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ifpg_pkg::REG_PRE_MARK:  r_pre_mark  <= i_cfg_wdata[ifpg_pkg::DUR_W-1:0];
                ifpg_pkg::REG_PRE_SPACE: r_pre_space <= i_cfg_wdata[ifpg_pkg::DUR_W-1:0];
                ifpg_pkg::REG_LONG_MARK: r_long_mark <= i_cfg_wdata[ifpg_pkg::DUR_W-1:0];
                ifpg_pkg::REG_SHORT:     r_short     <= i_cfg_wdata[ifpg_pkg::DUR_W-1:0];
                ifpg_pkg::REG_GAP:       r_gap       <= i_cfg_wdata[ifpg_pkg::GAP_W-1:0];
                ifpg_pkg::REG_HEADER:    r_header    <= i_cfg_wdata[ifpg_pkg::WORD_IN_W-1:0];
                default: ;
            endcase
        end
    end

    // next phase, count and frame for one transaction
    always_comb begin
        n_phase    = r_phase;
        n_ticks    = r_ticks;
        n_bit_cnt  = r_bit_cnt;
        n_frame    = r_frame;
        n_done     = 1'b0;
        n_rejected = 1'b0;
        if (i_operation == ifpg_pkg::OP_START) begin
            if (r_phase != ifpg_pkg::PH_IDLE) begin
                n_rejected = 1'b1;
            end else begin
                n_frame   = {WORD_BITS'(i_command_code), WORD_BITS'(i_device_id),
                             WORD_BITS'(r_header)};
                n_bit_cnt = '0;
                n_phase   = ifpg_pkg::PH_PRE_MARK;
                n_ticks   = f_min1(ifpg_pkg::TICK_W'(r_pre_mark));
            end
        end else if (r_phase != ifpg_pkg::PH_IDLE) begin
            n_ticks = ticks_dec;
            if (ticks_dec == '0) begin
                case (r_phase)
                    ifpg_pkg::PH_PRE_MARK: begin
                        n_phase = ifpg_pkg::PH_PRE_SPACE;
                        n_ticks = f_min1(ifpg_pkg::TICK_W'(r_pre_space));
                    end
                    ifpg_pkg::PH_PRE_SPACE: begin
                        n_bit_cnt = '0;
                        n_phase   = ifpg_pkg::PH_BIT_MARK;
                        n_ticks   = r_frame[0] ? long_ticks : short_ticks;
                    end
                    ifpg_pkg::PH_BIT_MARK: begin
                        n_phase = ifpg_pkg::PH_BIT_SPACE;
                        n_ticks = short_ticks;
                    end
                    ifpg_pkg::PH_BIT_SPACE: begin
                        if (r_bit_cnt == LAST_BIT) begin
                            n_phase = ifpg_pkg::PH_GAP;
                            n_ticks = f_min1(r_gap);
                        end else begin
                            // next bit moves to the bottom of the frame shifter
                            n_bit_cnt = r_bit_cnt + CNT_W'(1);
                            n_frame   = r_frame >> 1;
                            n_phase   = ifpg_pkg::PH_BIT_MARK;
                            n_ticks   = r_frame[1] ? long_ticks : short_ticks;
                        end
                    end
                    ifpg_pkg::PH_GAP: begin
                        n_phase   = ifpg_pkg::PH_IDLE;
                        n_ticks   = '0;
                        n_bit_cnt = '0;
                        n_done    = 1'b1;
                    end
                    default: begin
                        n_phase = ifpg_pkg::PH_IDLE;
                        n_ticks = '0;
                    end
                endcase
            end
        end
    end

    // sequencer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ifpg_pkg::PH_IDLE;
            r_ticks   <= '0;
            r_bit_cnt <= '0;
        end else if (in_accept) begin
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_bit_cnt <= n_bit_cnt;
        end
    end

    // frame shifter
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_frame <= n_frame;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_carrier  <= (n_phase == ifpg_pkg::PH_PRE_MARK) ||
                          (n_phase == ifpg_pkg::PH_BIT_MARK);
            r_busy     <= (n_phase != ifpg_pkg::PH_IDLE);
            r_done     <= n_done;
            r_rejected <= n_rejected;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_carrier_on     = r_carrier;
    assign o_busy_res       = r_busy;
    assign o_frame_done     = r_done;
    assign o_start_rejected = r_rejected;

endmodule

[rtl/ifpg_checker.sv]
// port-level checks for the infrared frame pulse generator, bound to the top level
module ifpg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic i_operation,
    input logic o_valid,
    input logic i_stall,
    input logic o_carrier_on,
    input logic o_busy_res,
    input logic o_frame_done,
    input logic o_start_rejected
);

    // every accepted transaction shows a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted transaction produced no result");

    // a held result does not change
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_carrier_on) && $stable(o_busy_res)
                                  && $stable(o_frame_done) && $stable(o_start_rejected)))
        else $error("stalled result changed");

    // carrier or a refused start only while a frame is running, and done only when back to idle
    a_carrier_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_carrier_on || o_start_rejected)) |-> o_busy_res)
        else $error("carrier or reject reported while idle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> (!o_busy_res && !o_carrier_on && !o_start_rejected))
        else $error("frame done reported while still busy");

    // a start never completes a frame in the same transaction
    a_start_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_operation == ifpg_pkg::OP_START)) |=> !o_frame_done)
        else $error("frame done on a start transaction");

endmodule

bind ir_frame_pulse_generator_top ifpg_checker u_ifpg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_operation      (i_operation),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_carrier_on     (o_carrier_on),
    .o_busy_res       (o_busy_res),
    .o_frame_done     (o_frame_done),
    .o_start_rejected (o_start_rejected)
);

[tb/ir_frame_shadow_pkg.sv]
// scoreboard class that mirrors the infrared frame pulse generator
package ir_frame_shadow_pkg;

    import ifpg_pkg::*;

    // word width used by the testbench build of the block
    localparam int unsigned WORD_BITS  = 16;
    localparam int unsigned FRAME_BITS = 3 * WORD_BITS;

    // register indexes beyond the list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_STRAY_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STRAY_HI = 3'd7;

    // one result transaction
    typedef struct packed {
        logic carrier_on;
        logic busy;
        logic done;
        logic rejected;
    } pulse_res_t;

    class ir_frame_shadow;

        // register copies, 17 bits wide so the gap register fits
        logic [GAP_W-1:0] pre_mark;
        logic [GAP_W-1:0] pre_space;
        logic [GAP_W-1:0] long_mark;
        logic [GAP_W-1:0] short_time;
        logic [GAP_W-1:0] gap_len;
        logic [WORD_IN_W-1:0] header;

        // frame sequencer state
        logic [PHASE_W-1:0]    phase;
        logic [TICK_W-1:0]     ticks;
        int unsigned           bit_idx;
        logic [FRAME_BITS-1:0] frame_word;

        // results still owed by the block, oldest first
        pulse_res_t pulse_q[$];

        int unsigned mismatches;
        int unsigned results_checked;
        int unsigned frames_ended;
        int unsigned starts_refused;

        function new();
            pre_mark        = {1'b0, RST_PRE_MARK};
            pre_space       = {1'b0, RST_PRE_SPACE};
            long_mark       = {1'b0, RST_LONG_MARK};
            short_time      = {1'b0, RST_SHORT};
            gap_len         = RST_GAP;
            header          = RST_HEADER;
            phase           = PH_IDLE;
            ticks           = '0;
            bit_idx         = 0;
            frame_word      = '0;
            mismatches      = 0;
            results_checked = 0;
            frames_ended    = 0;
            starts_refused  = 0;
        endfunction

        // register write, masked to the register width
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PRE_MARK:  pre_mark   = {1'b0, data[DUR_W-1:0]};
                REG_PRE_SPACE: pre_space  = {1'b0, data[DUR_W-1:0]};
                REG_LONG_MARK: long_mark  = {1'b0, data[DUR_W-1:0]};
                REG_SHORT:     short_time = {1'b0, data[DUR_W-1:0]};
                REG_GAP:       gap_len    = data[GAP_W-1:0];
                REG_HEADER:    header     = data[WORD_IN_W-1:0];
                default: ;
            endcase
        endfunction

        // a zero duration counts as one tick
        function logic [TICK_W-1:0] at_least_one(logic [GAP_W-1:0] v);
            return (v == '0) ? TICK_W'(1) : v;
        endfunction

        function void load_bit_mark();
            phase = PH_BIT_MARK;
            ticks = at_least_one(frame_word[bit_idx] ? long_mark : short_time);
        endfunction

        // move to the next phase once the count has run out
        function logic advance_phase();
            logic ended;
            ended = 1'b0;
            case (phase)
                PH_PRE_MARK: begin
                    phase = PH_PRE_SPACE;
                    ticks = at_least_one(pre_space);
                end
                PH_PRE_SPACE: begin
                    bit_idx = 0;
                    load_bit_mark();
                end
                PH_BIT_MARK: begin
                    phase = PH_BIT_SPACE;
                    ticks = at_least_one(short_time);
                end
                PH_BIT_SPACE: begin
                    bit_idx++;
                    if (bit_idx >= FRAME_BITS) begin
                        phase = PH_GAP;
                        ticks = at_least_one(gap_len);
                    end else begin
                        load_bit_mark();
                    end
                end
                PH_GAP: begin
                    phase   = PH_IDLE;
                    ticks   = '0;
                    bit_idx = 0;
                    ended   = 1'b1;
                end
                default: begin
                    phase = PH_IDLE;
                    ticks = '0;
                end
            endcase
            return ended;
        endfunction

        // accepted input transaction: work out the result it causes
        function void absorb_txn(input logic op, input logic [WORD_IN_W-1:0] dev,
                                 input logic [WORD_IN_W-1:0] cmd);
            pulse_res_t res;
            res = '0;
            if (op == OP_START) begin
                if (phase != PH_IDLE) begin
                    res.rejected = 1'b1;
                    starts_refused++;
                end else begin
                    // lsb of the header goes out first, the command last
                    frame_word = {cmd, dev, header};
                    bit_idx    = 0;
                    phase      = PH_PRE_MARK;
                    ticks      = at_least_one(pre_mark);
                end
            end else if (phase != PH_IDLE) begin
                if (ticks != '0)
                    ticks--;
                if (ticks == '0)
                    res.done = advance_phase();
            end
            if (res.done)
                frames_ended++;
            res.carrier_on = (phase == PH_PRE_MARK) || (phase == PH_BIT_MARK);
            res.busy       = (phase != PH_IDLE);
            pulse_q.push_back(res);
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        // accepted result transaction against the oldest expectation
        function void compare_result(pulse_res_t got);
            pulse_res_t want;
            results_checked++;
            if (pulse_q.size() == 0) begin
                note_failure($sformatf("unexpected result: carrier=%0b busy=%0b done=%0b rej=%0b",
                             got.carrier_on, got.busy, got.done, got.rejected));
                return;
            end
            want = pulse_q.pop_front();
            if (got.carrier_on !== want.carrier_on || got.busy !== want.busy ||
                got.done !== want.done || got.rejected !== want.rejected)
                note_failure($sformatf(
                    "result %0d: expected carrier=%0b busy=%0b done=%0b rej=%0b, got %0b %0b %0b %0b",
                    results_checked, want.carrier_on, want.busy, want.done, want.rejected,
                    got.carrier_on, got.busy, got.done, got.rejected));
        endfunction

        function int unsigned pending();
            return pulse_q.size();
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

    endclass

endpackage

[tb/tb_ir_frame_pulse_generator_top.sv]
// testbench top: drives tick and start transactions and checks every result
module tb_ir_frame_pulse_generator_top;

    localparam int RAND_ITEMS     = 250;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int TAIL_CYCLES    = 5;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_wr_en;
    logic [ifpg_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [ifpg_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                            i_valid;
    logic                            o_stall;
    logic                            i_operation;
    logic [ifpg_pkg::WORD_IN_W-1:0]  i_device_id;
    logic [ifpg_pkg::WORD_IN_W-1:0]  i_command_code;
    logic                            o_valid;
    logic                            i_stall;
    logic                            o_carrier_on;
    logic                            o_busy_res;
    logic                            o_frame_done;
    logic                            o_start_rejected;

    ir_frame_shadow_pkg::ir_frame_shadow shadow;

    bit                         tx_gaps_on  = 1'b0;
    bit                         rx_stall_on = 1'b0;
    bit                         stall_level = 1'b0;
    int                         burst_left  = 0;
    int                         stall_run   = 0;
    int                         quiet_cycles = 0;
    int                         tx_count    = 0;
    int                         reg_writes  = 0;
    int                         rand_base;
    logic [ifpg_pkg::GAP_W-1:0] reg_plan [6];

    ir_frame_pulse_generator_top #(.WORD_BITS(ir_frame_shadow_pkg::WORD_BITS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_device_id      (i_device_id),
        .i_command_code   (i_command_code),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_carrier_on     (o_carrier_on),
        .o_busy_res       (o_busy_res),
        .o_frame_done     (o_frame_done),
        .o_start_rejected (o_start_rejected)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stall pattern: a stalled run is always followed by a free run
    always @(posedge i_clk) begin
        if (!rx_stall_on) begin
            i_stall     <= 1'b0;
            stall_level = 1'b0;
            stall_run   = 0;
        end else if (stall_run == 0) begin
            stall_level = !stall_level && ($urandom_range(0, 1) == 1);
            i_stall     <= stall_level;
            stall_run   = stall_level ? $urandom_range(1, 12) : $urandom_range(1, 16);
        end else begin
            stall_run--;
        end
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        ir_frame_shadow_pkg::pulse_res_t got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = {o_carrier_on, o_busy_res, o_frame_done, o_start_rejected};
                shadow.compare_result(got);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // one input transaction, with the sender's burst and gap pattern
    task automatic send_txn(input logic op, input logic [ifpg_pkg::WORD_IN_W-1:0] dev,
                            input logic [ifpg_pkg::WORD_IN_W-1:0] cmd);
        int gap_cycles;
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_device_id    <= dev;
        i_command_code <= cmd;
        do @(posedge i_clk); while (o_stall);
        shadow.absorb_txn(op, dev, cmd);
        tx_count++;
        if (tx_gaps_on) begin
            if (burst_left == 0) begin
                gap_cycles = $urandom_range(1, 8);
                i_valid    <= 1'b0;
                repeat (gap_cycles) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // hold off the sender until every expected result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ifpg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ifpg_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        shadow.write_reg(idx, data);
        reg_writes++;
    endtask

    // write every register from reg_plan, optionally poking the unused indexes
    task automatic program_regs(input bit add_stray);
        drain_results();
        cfg_write(ifpg_pkg::REG_PRE_MARK,  reg_plan[ifpg_pkg::REG_PRE_MARK]);
        cfg_write(ifpg_pkg::REG_PRE_SPACE, reg_plan[ifpg_pkg::REG_PRE_SPACE]);
        cfg_write(ifpg_pkg::REG_LONG_MARK, reg_plan[ifpg_pkg::REG_LONG_MARK]);
        cfg_write(ifpg_pkg::REG_SHORT,     reg_plan[ifpg_pkg::REG_SHORT]);
        cfg_write(ifpg_pkg::REG_GAP,       reg_plan[ifpg_pkg::REG_GAP]);
        cfg_write(ifpg_pkg::REG_HEADER,    reg_plan[ifpg_pkg::REG_HEADER]);
        if (add_stray) begin
            cfg_write(ir_frame_shadow_pkg::REG_STRAY_LO, ifpg_pkg::CFG_DATA_W'($urandom));
            cfg_write(ir_frame_shadow_pkg::REG_STRAY_HI, ifpg_pkg::CFG_DATA_W'($urandom));
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [ifpg_pkg::WORD_IN_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return ifpg_pkg::WORD_IN_W'($urandom);
        endcase
    endfunction

    // short durations of at most 6 ticks keep frames short; bit 16 is masked away
    function automatic logic [ifpg_pkg::GAP_W-1:0] rand_dur();
        logic [ifpg_pkg::DUR_W-1:0] v;
        v = ($urandom_range(0, 7) == 0) ? ifpg_pkg::DUR_W'($urandom_range(3, 6))
                                        : ifpg_pkg::DUR_W'($urandom_range(0, 2));
        return {1'($urandom_range(0, 1)), v};
    endfunction

    function automatic void plan_small_regs();
        reg_plan[ifpg_pkg::REG_PRE_MARK]  = rand_dur();
        reg_plan[ifpg_pkg::REG_PRE_SPACE] = rand_dur();
        reg_plan[ifpg_pkg::REG_LONG_MARK] = rand_dur();
        reg_plan[ifpg_pkg::REG_SHORT]     = rand_dur();
        reg_plan[ifpg_pkg::REG_GAP]       = ifpg_pkg::GAP_W'($urandom_range(0, 4));
        reg_plan[ifpg_pkg::REG_HEADER]    = {1'($urandom_range(0, 1)), rand_word()};
    endfunction

    task automatic run_until_idle();
        while (shadow.busy())
            send_txn(ifpg_pkg::OP_TICK, ifpg_pkg::WORD_IN_W'($urandom),
                     ifpg_pkg::WORD_IN_W'($urandom));
    endtask

    // one frame with random content, refused starts mixed in, at most one hold-off
    task automatic run_random_frame();
        int lead;
        int pause_at;
        int steps;
        plan_small_regs();
        program_regs($urandom_range(0, 2) == 0);
        tx_gaps_on  = ($urandom_range(0, 3) != 0);
        rx_stall_on = ($urandom_range(0, 3) != 0);
        lead = $urandom_range(0, 2);
        repeat (lead) send_txn(ifpg_pkg::OP_TICK, rand_word(), rand_word());
        send_txn(ifpg_pkg::OP_START, rand_word(), rand_word());
        pause_at = $urandom_range(1, 90);
        steps    = 0;
        while (shadow.busy()) begin
            steps++;
            if (steps == pause_at) begin
                if ($urandom_range(0, 1) == 1) begin
                    // new timing mid-frame, picked up at the next phase change
                    plan_small_regs();
                    program_regs(1'b0);
                end else begin
                    drain_results();
                end
            end
            send_txn(($urandom_range(0, 15) == 0) ? ifpg_pkg::OP_START : ifpg_pkg::OP_TICK,
                     ifpg_pkg::WORD_IN_W'($urandom), ifpg_pkg::WORD_IN_W'($urandom));
        end
        lead = $urandom_range(0, 2);
        repeat (lead) send_txn(ifpg_pkg::OP_TICK, rand_word(), rand_word());
    endtask

    // main sequence
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_wdata    <= '0;
        i_valid        <= 1'b0;
        i_operation    <= ifpg_pkg::OP_TICK;
        i_device_id    <= '0;
        i_command_code <= '0;
        shadow = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick while idle
        send_txn(ifpg_pkg::OP_TICK, '1, '1);

        // short timing with the header left at its reset value, a refused start,
        // and a long mark on the very last bit
        drain_results();
        cfg_write(ifpg_pkg::REG_PRE_MARK,  ifpg_pkg::CFG_DATA_W'(2));
        cfg_write(ifpg_pkg::REG_PRE_SPACE, ifpg_pkg::CFG_DATA_W'(1));
        cfg_write(ifpg_pkg::REG_LONG_MARK, ifpg_pkg::CFG_DATA_W'(3));
        cfg_write(ifpg_pkg::REG_SHORT,     ifpg_pkg::CFG_DATA_W'(1));
        cfg_write(ifpg_pkg::REG_GAP,       ifpg_pkg::CFG_DATA_W'(2));
        i_cfg_wr_en <= 1'b0;
        send_txn(ifpg_pkg::OP_START, '0, 16'h8000);
        send_txn(ifpg_pkg::OP_START, '1, '1);
        run_until_idle();

        // zero durations, written with bit 16 set on the 16-bit registers
        reg_plan[ifpg_pkg::REG_PRE_MARK]  = 17'h10000;
        reg_plan[ifpg_pkg::REG_PRE_SPACE] = 17'h10000;
        reg_plan[ifpg_pkg::REG_LONG_MARK] = 17'h10000;
        reg_plan[ifpg_pkg::REG_SHORT]     = 17'h10000;
        reg_plan[ifpg_pkg::REG_GAP]       = '0;
        reg_plan[ifpg_pkg::REG_HEADER]    = 17'h1ffff;
        program_regs(1'b1);
        send_txn(ifpg_pkg::OP_START, '1, '1);
        send_txn(ifpg_pkg::OP_TICK, '0, '0);
        send_txn(ifpg_pkg::OP_START, '0, '0);
        run_until_idle();

        // random frames with idling on both sides
        rand_base = tx_count;
        while (tx_count - rand_base < RAND_ITEMS)
            run_random_frame();

        tx_gaps_on = 1'b0;
        drain_results();
        rx_stall_on = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d transactions, checked %0d results, %0d register writes",
                 tx_count, shadow.results_checked, reg_writes);
        $display("frames completed %0d, starts refused %0d, mismatches %0d, left over %0d",
                 shadow.frames_ended, shadow.starts_refused, shadow.mismatches,
                 shadow.pending());
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
